FILE: hdl/quad_execute_unit_macros.svh
// Assertion macros shared by the quad execute unit checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef QUAD_EXECUTE_UNIT_MACROS_SVH
`define QUAD_EXECUTE_UNIT_MACROS_SVH
// same-cycle implication
`define QEU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define QEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hdl/qeu_pkg.sv
// Types and opcodes for the quad execute unit.
// No dependencies.
package qeu_pkg;

  localparam int INDEX_SPAN = 128;  // codes reachable by a 7-bit temp field

  typedef enum logic [4:0] {
    CMD_MOV_IM = 5'd0,  CMD_MOV  = 5'd1,  CMD_NOT   = 5'd2,  CMD_NEG   = 5'd3,
    CMD_MUL    = 5'd4,  CMD_IMUL = 5'd5,  CMD_DIV   = 5'd6,  CMD_IDIV  = 5'd7,
    CMD_ADD    = 5'd8,  CMD_SUB  = 5'd9,  CMD_EQ    = 5'd10, CMD_NE    = 5'd11,
    CMD_LT     = 5'd12, CMD_BELOW = 5'd13, CMD_GT   = 5'd14, CMD_ABOVE = 5'd15,
    CMD_LE     = 5'd16, CMD_BE   = 5'd17, CMD_GE    = 5'd18, CMD_AE    = 5'd19,
    CMD_JMP    = 5'd20, CMD_JZ   = 5'd21, CMD_JNZ   = 5'd22, CMD_LABEL = 5'd23,
    CMD_CALL   = 5'd24, CMD_RET  = 5'd25, CMD_ARG   = 5'd26
  } cmd_t;

  typedef struct packed {
    logic [4:0]         cmd;
    logic [6:0]         target_temp;
    logic [6:0]         left_temp;
    logic [6:0]         right_temp;
    logic signed [63:0] immediate;
    logic [15:0]        jump_label;
    logic               returns_value;
    logic [6:0]         arg_slot;
    logic               callee_external;
  } in_word_t;

  typedef struct packed {
    logic [63:0] last_value;
    logic        last_is_void;
    logic        jump_taken;
    logic [15:0] jump_to;
    logic        finished;
    logic        frame_error;
  } out_word_t;

endpackage

FILE: hdl/qeu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qeu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/quad_execute_unit.sv
// Quad execute unit: one three-address quad per accepted word, one result word each.
// Moves, logic, add/sub, compares, jumps, calls, returns and args pass S_RDA, S_RDB,
// S_EXEC and S_WB; multiply adds S_ITER, divide adds S_NEGA, S_NEGB, S_ITER and S_FIX
// (one bit per cycle on the shared 64-bit adder). One quad in flight: the next is taken
// the cycle after the result is loaded, and later while the result word is stalled.
// Reset (rst, synchronous): frame depth 0, last value 0, void flag set, no result pending;
// temp and return-target memories are not cleared.
module quad_execute_unit #(
  parameter int FRAME_COUNT = 32,
  parameter int TEMP_COUNT  = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               quad_valid,
  output logic               quad_ready,
  input  qeu_pkg::in_word_t  quad,
  output logic               result_valid,
  input  logic               result_ready,
  output qeu_pkg::out_word_t result
);
  import qeu_pkg::*;

  localparam int FW = $clog2(FRAME_COUNT);
  localparam int TW = $clog2(TEMP_COUNT);
  localparam int AW = $clog2(FRAME_COUNT * TEMP_COUNT);
  localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDA  = 9'b000000010,  // read left temp
    S_RDB  = 9'b000000100,  // read right temp, capture left
    S_EXEC = 9'b000001000,  // right temp on RAM output; single-step ops
    S_NEGA = 9'b000010000,  // divide: magnitude of dividend
    S_NEGB = 9'b000100000,  // divide: magnitude of divisor
    S_ITER = 9'b001000000,  // one multiply or divide bit per cycle
    S_FIX  = 9'b010000000,  // divide: sign and divide-by-zero fix-up
    S_WB   = 9'b100000000   // write back, update state, load result
  } state_t;

  state_t      state;
  in_word_t    q;
  logic [FW-1:0] depth;
  logic [63:0] last_value;
  logic        last_void;
  logic [63:0] a_r, res, opa, opb, acc;
  logic [5:0]  cnt;
  logic        taken, bz, neg_res, sdiv;

  // temp index wrap table, worked out at elaboration
  logic [TW-1:0] mod_tab [INDEX_SPAN];
  for (genvar g = 0; g < INDEX_SPAN; g++) begin : g_mod
    assign mod_tab[g] = TW'(g % TEMP_COUNT);
  end

  cmd_t cmd;
  assign cmd = cmd_t'(q.cmd);

  // memories
  logic [AW-1:0] rd_addr, wr_addr;
  logic [TW-1:0] rd_idx, wr_idx;
  logic [FW-1:0] wr_frame;
  logic          wr_en;
  logic [63:0]   wr_val, ram_q;
  logic          rt_we;
  logic [TW-1:0] rt_q;

  assign rd_idx  = (state == S_RDA) ? mod_tab[q.left_temp] : mod_tab[q.right_temp];
  assign rd_addr = AW'(depth) * AW'(TEMP_COUNT) + AW'(rd_idx);
  assign wr_addr = AW'(wr_frame) * AW'(TEMP_COUNT) + AW'(wr_idx);

  qeu_ram #(.WIDTH(64), .DEPTH(FRAME_COUNT * TEMP_COUNT)) u_temps (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_val), .raddr(rd_addr), .rdata(ram_q)
  );

  qeu_ram #(.WIDTH(TW), .DEPTH(FRAME_COUNT)) u_targets (
    .clk(clk), .we(rt_we), .waddr(depth), .wdata(mod_tab[q.target_temp]),
    .raddr(depth - FW'(1)), .rdata(rt_q)
  );

  // shared adder/subtractor
  logic [63:0] add_x, add_y;
  logic        add_sub;
  logic [64:0] sum;
  logic        is_signed_cmp;

  always_comb begin
    is_signed_cmp = (cmd == CMD_LT) || (cmd == CMD_GT) || (cmd == CMD_LE) ||
                    (cmd == CMD_GE);
    add_x   = a_r;
    add_y   = ram_q;
    add_sub = 1'b1;
    case (state)
      S_EXEC: begin
        if (cmd == CMD_NEG) begin
          add_x = '0;
          add_y = a_r;
        end else if (cmd == CMD_ADD) begin
          add_sub = 1'b0;
        end else if (is_signed_cmp) begin
          add_x = a_r ^ SIGN;
          add_y = ram_q ^ SIGN;
        end
      end
      S_NEGA: begin
        add_x = '0;
        add_y = opa;
      end
      S_NEGB: begin
        add_x = '0;
        add_y = opb;
      end
      S_ITER: begin
        if (cmd == CMD_MUL || cmd == CMD_IMUL) begin
          add_x   = acc;
          add_y   = opa;
          add_sub = 1'b0;
        end else begin
          add_x = {acc[62:0], opa[63]};
          add_y = opb;
        end
      end
      S_FIX: begin
        add_x = '0;
        add_y = res;
      end
      default: ;
    endcase
    sum = {1'b0, add_x} + {1'b0, add_y ^ {64{add_sub}}} + 65'(add_sub);
  end

  // single-step results
  logic        eq, geq;
  logic [63:0] exec_res;
  assign eq  = (a_r == ram_q);
  assign geq = sum[64];  // no borrow: x >= y

  always_comb begin
    exec_res = '0;
    case (cmd)
      CMD_MOV_IM: exec_res = q.immediate;
      CMD_MOV:    exec_res = a_r;
      CMD_NOT:    exec_res = 64'(a_r == '0);
      CMD_NEG, CMD_ADD, CMD_SUB: exec_res = sum[63:0];
      CMD_EQ:     exec_res = 64'(eq);
      CMD_NE:     exec_res = 64'(!eq);
      CMD_LT, CMD_BELOW: exec_res = 64'(!geq);
      CMD_GT, CMD_ABOVE: exec_res = 64'(geq && !eq);
      CMD_LE, CMD_BE:    exec_res = 64'(!geq || eq);
      CMD_GE, CMD_AE:    exec_res = 64'(geq);
      default:    exec_res = '0;
    endcase
  end

  // iteration step
  logic        div_take;
  logic [63:0] acc_step, opa_step, opb_step;
  always_comb begin
    div_take = acc[63] | sum[64];
    if (cmd == CMD_MUL || cmd == CMD_IMUL) begin
      acc_step = opb[0] ? sum[63:0] : acc;
      opa_step = {opa[62:0], 1'b0};
      opb_step = {1'b0, opb[63:1]};
    end else begin
      acc_step = div_take ? sum[63:0] : {acc[62:0], opa[63]};
      opa_step = {opa[62:0], div_take};
      opb_step = opb;
    end
  end

  // write-back decisions
  logic last_frame, out_free, wb_fire, set_last, fin, ferr;
  logic [63:0] last_value_next;
  logic        last_void_next;
  logic [FW-1:0] depth_next;

  assign last_frame = (depth == FW'(FRAME_COUNT - 1));
  assign out_free   = !result_valid || result_ready;
  assign wb_fire    = (state == S_WB) && out_free;

  always_comb begin
    wr_en           = 1'b0;
    wr_frame        = depth;
    wr_idx          = mod_tab[q.target_temp];
    wr_val          = res;
    rt_we           = 1'b0;
    set_last        = 1'b0;
    fin             = 1'b0;
    ferr            = 1'b0;
    depth_next      = depth;
    last_void_next  = last_void;
    case (cmd)
      CMD_CALL: begin
        if (q.callee_external) begin
          wr_en          = 1'b1;
          wr_val         = '0;
          set_last       = 1'b1;
          last_void_next = 1'b1;
        end else if (last_frame) begin
          ferr = 1'b1;
        end else begin
          rt_we      = 1'b1;
          depth_next = depth + FW'(1);
        end
      end
      CMD_RET: begin
        if (depth == '0) begin
          fin = 1'b1;
        end else begin
          wr_en          = 1'b1;
          wr_frame       = depth - FW'(1);
          wr_idx         = rt_q;
          wr_val         = q.returns_value ? a_r : '0;
          set_last       = 1'b1;
          last_void_next = !q.returns_value;
          depth_next     = depth - FW'(1);
        end
      end
      CMD_ARG: begin
        if (last_frame) begin
          ferr = 1'b1;
        end else begin
          wr_en          = 1'b1;
          wr_frame       = depth + FW'(1);
          wr_idx         = mod_tab[q.arg_slot];
          wr_val         = a_r;
          set_last       = 1'b1;
          last_void_next = 1'b0;
        end
      end
      default: begin
        if (q.cmd <= CMD_AE) begin
          wr_en          = 1'b1;
          set_last       = 1'b1;
          last_void_next = 1'b0;
        end
      end
    endcase
    last_value_next = set_last ? wr_val : last_value;
    // only commit in the cycle that loads the result
    wr_en = wr_en && wb_fire;
    rt_we = rt_we && wb_fire;
  end

  assign quad_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      depth        <= '0;
      last_value   <= '0;
      last_void    <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      // drop the word once taken, unless a new one loads in the same cycle
      if (result_valid && result_ready && !wb_fire) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (quad_valid) begin
            q     <= quad;
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          a_r   <= ram_q;
          state <= S_EXEC;
        end
        S_EXEC: begin
          res   <= exec_res;
          taken <= (cmd == CMD_JMP) || (cmd == CMD_JZ && a_r == '0) ||
                   (cmd == CMD_JNZ && a_r != '0);
          opa   <= a_r;
          opb   <= ram_q;
          acc   <= '0;
          cnt   <= '0;
          bz      <= (ram_q == '0);
          neg_res <= (cmd == CMD_IDIV) && (a_r[63] ^ ram_q[63]);
          sdiv    <= (cmd == CMD_IDIV);
          if (cmd == CMD_MUL || cmd == CMD_IMUL) begin
            state <= S_ITER;
          end else if (cmd == CMD_DIV || cmd == CMD_IDIV) begin
            state <= S_NEGA;
          end else begin
            state <= S_WB;
          end
        end
        S_NEGA: begin
          if (sdiv && opa[63]) opa <= sum[63:0];
          state <= S_NEGB;
        end
        S_NEGB: begin
          if (sdiv && opb[63]) opb <= sum[63:0];
          state <= S_ITER;
        end
        S_ITER: begin
          acc <= acc_step;
          opa <= opa_step;
          opb <= opb_step;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            if (cmd == CMD_MUL || cmd == CMD_IMUL) begin
              res   <= acc_step;
              state <= S_WB;
            end else begin
              res   <= opa_step;
              state <= S_FIX;
            end
          end
        end
        S_FIX: begin
          if (bz) begin
            res <= '1;
          end else if (neg_res) begin
            res <= sum[63:0];
          end
          state <= S_WB;
        end
        S_WB: begin
          // hold until the output register is free
          if (out_free) begin
            depth        <= depth_next;
            last_value   <= last_value_next;
            last_void    <= last_void_next;
            result_valid <= 1'b1;
            result.last_value   <= last_value_next;
            result.last_is_void <= last_void_next;
            result.jump_taken   <= taken;
            result.jump_to      <= taken ? q.jump_label : 16'd0;
            result.finished     <= fin;
            result.frame_error  <= ferr;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/qeu_checker.sv
// Port-level checker for the quad execute unit, bound to the top level.
// Depends on qeu_pkg and quad_execute_unit_macros.svh.
`include "quad_execute_unit_macros.svh"
module qeu_checker (
  input logic               clk,
  input logic               rst,
  input logic               quad_valid,
  input logic               quad_ready,
  input qeu_pkg::in_word_t  quad,
  input logic               result_valid,
  input logic               result_ready,
  input qeu_pkg::out_word_t result
);
  import qeu_pkg::*;

  `QEU_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result word changed")
  `QEU_ASSERT_NOW(a_jump_to_zero, result_valid && !result.jump_taken, result.jump_to == 16'd0, "jump_to set without a taken jump")
  `QEU_ASSERT_NOW(a_fin_ferr, result_valid, !(result.finished && result.frame_error), "finished and frame_error together")
  `QEU_ASSERT_NEXT(a_one_in_flight, quad_valid && quad_ready, !quad_ready, "second quad taken while one is in flight")
endmodule

bind quad_execute_unit qeu_checker u_qeu_checker (.*);
